[sv/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned RemW  = 2;

  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] PayMask   = 8'h3F;

  localparam logic [CpW-1:0] CpMax  = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [CpW-1:0]  pv;
    logic [RemW-1:0] rem;
    logic [LenW-1:0] len;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic            valid;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            status;
  } dec_result_t;

endpackage

[sv/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step
// Combinational decode of one byte against the current sequence state.
// ----------------------------------------------------------------------------
module u8d_step (
  input  u8d_pkg::dec_state_t         state_i,
  input  logic [u8d_pkg::ByteW-1:0]   byte_i,
  input  logic                        last_i,
  output u8d_pkg::dec_state_t         state_o,
  output u8d_pkg::dec_result_t        result_o
);
  import u8d_pkg::*;

  logic [CpW-1:0]  shifted;
  logic [RemW-1:0] rem_dec;
  logic            is_cont;
  logic            bad_value;
  dec_state_t      idle_state;
  dec_result_t     err_result;
  dec_result_t     none_result;

  assign idle_state  = '{pv: '0, rem: '0, len: '0};
  assign err_result  = '{valid: 1'b1, cp: '0, len: '0, status: StatusErr};
  assign none_result = '{valid: 1'b0, cp: '0, len: '0, status: StatusOk};

  assign is_cont   = (byte_i & ContMask) == ContCode;
  assign shifted   = {state_i.pv[CpW-7:0], byte_i[5:0]};
  assign rem_dec   = state_i.rem - RemW'(1);
  assign bad_value = (shifted > CpMax) || ((shifted >= SurrLo) && (shifted <= SurrHi));

  always_comb begin
    state_o  = idle_state;
    result_o = none_result;
    if (state_i.rem == '0) begin
      priority if ((byte_i & Lead4Mask) == Lead4Code) begin
        state_o = '{pv: CpW'(byte_i[2:0]), rem: RemW'(3), len: Len4};
      end else if ((byte_i & Lead3Mask) == Lead3Code) begin
        state_o = '{pv: CpW'(byte_i[3:0]), rem: RemW'(2), len: Len3};
      end else if ((byte_i & Lead2Mask) == Lead2Code) begin
        state_o = '{pv: CpW'(byte_i[4:0]), rem: RemW'(1), len: Len2};
      end else if (!byte_i[7]) begin
        result_o = '{valid: 1'b1, cp: CpW'(byte_i[6:0]), len: Len1, status: StatusOk};
      end else begin
        result_o = err_result;
      end
      // A multi-byte lead that is also the last byte of the string is an error.
      if (state_o.rem != '0 && last_i) begin
        state_o  = idle_state;
        result_o = err_result;
      end
    end else if (!is_cont) begin
      result_o = err_result;
    end else if (rem_dec == '0) begin
      if (bad_value) begin
        result_o = err_result;
      end else begin
        result_o = '{valid: 1'b1, cp: shifted, len: state_i.len, status: StatusOk};
      end
    end else if (last_i) begin
      result_o = err_result;
    end else begin
      state_o = '{pv: shifted, rem: rem_dec, len: state_i.len};
    end
  end

endmodule

[sv/utf8_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// UTF-8 byte stream to Unicode code point decoder. Bytes enter one per
// request with an end-of-string flag; each completed character, and each
// error, leaves as one result request carrying the code point, the sequence
// length and a status bit. Overlong forms are accepted. On an error the
// partial sequence and the offending byte are dropped and decoding restarts
// at the next lead byte. The block takes one byte every cycle unless the
// output stalls: a byte is captured in the input register, decoded against
// the sequence state by one level of logic, and its result lands in the
// output register. The only thing that holds the input back is a result that
// still waits in the output register while the next byte also makes one.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u8d_pkg::ByteW-1:0]   byte_value_i,
  input  logic                        end_of_string_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u8d_pkg::CpW-1:0]     code_point_o,
  output logic [u8d_pkg::LenW-1:0]    seq_length_o,
  output logic                        status_o
);
  import u8d_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  dec_state_t       state_q, state_d;
  dec_result_t      step_res;
  logic             out_valid_q;
  logic [CpW-1:0]   cp_q;
  logic [LenW-1:0]  len_q;
  logic             status_q;
  logic             out_free;
  logic             advance;

  u8d_step u_step (
    .state_i  (state_q),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  // A byte that makes no result can always move on.
  assign advance    = in_valid_q && (!step_res.valid || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '{pv: '0, rem: '0, len: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && step_res.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_value_i;
      last_q <= end_of_string_i;
    end
    if (advance && step_res.valid) begin
      cp_q     <= step_res.cp;
      len_q    <= step_res.len;
      status_q <= step_res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign seq_length_o = len_q;
  assign status_o     = status_q;

  // An error result never carries a code point or a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusErr) |-> (code_point_o == '0) && (seq_length_o == '0))
    else $error("error result with nonzero payload");

  // A good result is a scalar value of one to four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusOk) |->
      (seq_length_o != '0) && (seq_length_o <= Len4) && (code_point_o <= CpMax))
    else $error("good result out of range");

  // While waiting for a lead byte the state is fully cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.rem == '0) |-> (state_q.pv == '0) && (state_q.len == '0))
    else $error("stale sequence state while idle");

  // A sequence in progress always expects fewer bytes than its length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.rem != '0) |-> (state_q.len > LenW'(state_q.rem)))
    else $error("sequence length below remaining count");

endmodule
